FILE: sv/dfrl_pkg.sv
`timescale 1ns / 1ps
// Package for the recent-id list: sizes, field widths and shared types.
// Depends on nothing; every module of the block imports it.
package dfrl_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int FILL_W     = 5;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef logic [KEY_BITS-1:0] key_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

    localparam logic MODE_PRESENT = 1'b0;
    localparam logic MODE_READOUT = 1'b1;

    typedef struct packed {
        logic             shift_en;
        logic [CNT_W-1:0] held;
        logic [IDX_W-1:0] sel_idx;
    } chain_ctrl_t;

    typedef struct packed {
        logic hit;
        key_t sel_key;
    } chain_stat_t;

endpackage

FILE: sv/dfrl_cell.sv
`timescale 1ns / 1ps
// One slot of the list: holds an id, compares it to the presented id and
// takes its neighbor's id when the list shifts. Depends on dfrl_pkg.
module dfrl_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  logic            slot_valid,
    input  dfrl_pkg::key_t  prev_key,
    input  dfrl_pkg::key_t  cmp_key,
    output dfrl_pkg::key_t  key,
    output logic            match
);
    import dfrl_pkg::*;

    key_t key_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg <= prev_key;
        end
    end

    assign key   = key_reg;
    assign match = slot_valid && (key_reg == cmp_key);

endmodule

FILE: sv/dfrl_chain.sv
`timescale 1ns / 1ps
// Row of list cells, newest at slot 0, with the hit reduction and the
// slot read select. Depends on dfrl_pkg and dfrl_cell.
module dfrl_chain (
    input  logic                  aclk,
    input  dfrl_pkg::chain_ctrl_t ctrl,
    input  dfrl_pkg::key_t        in_key,
    output dfrl_pkg::chain_stat_t stat
);
    import dfrl_pkg::*;

    key_t              cell_key [DEPTH];
    logic [DEPTH-1:0]  cell_match;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        key_t prev;
        logic slot_valid;

        if (i == 0) begin : g_head
            assign prev = in_key;
        end else begin : g_body
            assign prev = cell_key[i-1];
        end

        assign slot_valid = ctrl.held > CNT_W'(i);

        dfrl_cell u_cell (
            .aclk       (aclk),
            .shift_en   (ctrl.shift_en),
            .slot_valid (slot_valid),
            .prev_key   (prev),
            .cmp_key    (in_key),
            .key        (cell_key[i]),
            .match      (cell_match[i])
        );
    end

    assign stat.hit     = |cell_match;
    assign stat.sel_key = cell_key[ctrl.sel_idx];

endmodule

FILE: sv/dfrl_top_unused_guard.sv
`timescale 1ns / 1ps
// Output word register for the recent-id list: holds one result word until
// the sink takes it. Depends on dfrl_pkg.
module dfrl_out_reg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic                       m_ready,
    input  logic                       hit_in,
    input  logic                       evicted_in,
    input  logic                       entry_valid_in,
    input  dfrl_pkg::key_t             out_key_in,
    input  logic [dfrl_pkg::FILL_W-1:0] fill_in,
    input  logic                       last_in,
    output logic                       free,
    output logic                       m_valid,
    output logic                       m_hit,
    output logic                       m_evicted,
    output logic                       m_entry_valid,
    output dfrl_pkg::key_t             m_out_key,
    output logic [dfrl_pkg::FILL_W-1:0] m_fill_count,
    output logic                       m_last
);
    import dfrl_pkg::*;

    logic              valid_reg, valid_next;
    logic              hit_reg, evicted_reg, entry_valid_reg, last_reg;
    key_t              key_reg;
    logic [FILL_W-1:0] fill_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hit_reg         <= hit_in;
            evicted_reg     <= evicted_in;
            entry_valid_reg <= entry_valid_in;
            key_reg         <= out_key_in;
            fill_reg        <= fill_in;
            last_reg        <= last_in;
        end
    end

    assign m_valid       = valid_reg;
    assign m_hit         = hit_reg;
    assign m_evicted     = evicted_reg;
    assign m_entry_valid = entry_valid_reg;
    assign m_out_key     = key_reg;
    assign m_fill_count  = fill_reg;
    assign m_last        = last_reg;

endmodule

FILE: sv/dedup_fifo_recent_list.sv
`timescale 1ns / 1ps
// Recent-id list top level: control, capacity register and fill count.
// Depends on dfrl_pkg, dfrl_chain and dfrl_out_reg.
// A presented id gives its result word in the cycle after acceptance; a new id
// is taken every cycle while the result sink keeps up, as all cells compare and
// shift together. A readout moves to the read state, then gives one word per
// cycle from the shared slot select while the sink keeps up (an empty list gives
// its single word directly); no input is taken until it ends.
// Synchronous active-low reset empties the list and sets capacity to 16.
module dedup_fifo_recent_list (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dfrl_pkg::CAP_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  dfrl_pkg::key_t              s_item_key,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic                        m_evicted,
    output logic                        m_entry_valid,
    output dfrl_pkg::key_t              m_out_key,
    output logic [dfrl_pkg::FILL_W-1:0] m_fill_count,
    output logic                        m_last
);
    import dfrl_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CAP_W-1:0]  cap_reg;

    chain_ctrl_t       ctrl;
    chain_stat_t       stat;

    logic              out_free;
    logic              load;
    logic              o_hit, o_evicted, o_entry_valid, o_last;
    key_t              o_key;
    logic [FILL_W-1:0] o_fill;

    logic              accept;
    logic              evict;
    logic              rd_last;
    logic [CAP_W-1:0]  cap_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    assign cap_eff = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign evict   = (CMP_W'(held_reg) >= CMP_W'(cap_eff))
                  || (CMP_W'(held_reg) >= CMP_W'(DEPTH));

    assign s_ready = (state_reg == ST_IDLE) && out_free;
    assign accept  = s_valid && s_ready;
    assign rd_last = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == held_reg;

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        rd_idx_next   = rd_idx_reg;
        load          = 1'b0;
        o_hit         = 1'b0;
        o_evicted     = 1'b0;
        o_entry_valid = 1'b0;
        o_key         = '0;
        o_fill        = FILL_W'(held_reg);
        o_last        = 1'b1;
        ctrl.shift_en = 1'b0;
        ctrl.held     = held_reg;
        ctrl.sel_idx  = IDX_W'(held_reg - CNT_W'(1));

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == MODE_READOUT) begin
                        if (held_reg == '0) begin
                            load = 1'b1;
                        end else begin
                            state_next  = ST_READ;
                            rd_idx_next = '0;
                        end
                    end else begin
                        load = 1'b1;
                        if (stat.hit) begin
                            o_hit = 1'b1;
                        end else begin
                            ctrl.shift_en = 1'b1;
                            if (evict) begin
                                o_evicted = 1'b1;
                                o_key     = stat.sel_key;
                            end else begin
                                held_next = held_reg + CNT_W'(1);
                            end
                            o_fill = FILL_W'(held_next);
                        end
                    end
                end
            end
            ST_READ: begin
                ctrl.sel_idx = rd_idx_reg;
                if (out_free) begin
                    load          = 1'b1;
                    o_entry_valid = 1'b1;
                    o_key         = stat.sel_key;
                    o_last        = rd_last;
                    if (rd_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            held_reg   <= '0;
            rd_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    dfrl_chain u_chain (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .in_key (s_item_key),
        .stat   (stat)
    );

    dfrl_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .m_ready        (m_ready),
        .hit_in         (o_hit),
        .evicted_in     (o_evicted),
        .entry_valid_in (o_entry_valid),
        .out_key_in     (o_key),
        .fill_in        (o_fill),
        .last_in        (o_last),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_hit          (m_hit),
        .m_evicted      (m_evicted),
        .m_entry_valid  (m_entry_valid),
        .m_out_key      (m_out_key),
        .m_fill_count   (m_fill_count),
        .m_last         (m_last)
    );

endmodule

FILE: dv/dfrl_list_checker.sv
`timescale 1ns / 1ps
// Checker for the recent-id list: watches the capacity, input and result channels.
// Keeps its own copy of the list, predicts every result word and compares it.
// Depends on dfrl_pkg.
module dfrl_list_checker
    import dfrl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_mode,
    input  key_t              s_item_key,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_hit,
    input  logic              m_evicted,
    input  logic              m_entry_valid,
    input  key_t              m_out_key,
    input  logic [FILL_W-1:0] m_fill_count,
    input  logic              m_last,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic              entry_valid;
        key_t              out_key;
        logic [FILL_W-1:0] fill_count;
        logic              last;
    } list_word_t;

    key_t             recent_ids [DEPTH];
    int               held;
    logic [CAP_W-1:0] capacity;
    list_word_t       expected_words [$];
    list_word_t       want;

    function automatic int kept_limit();
        int lim;
        lim = int'(capacity);
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > DEPTH) begin
            lim = DEPTH;
        end
        return lim;
    endfunction

    function automatic void add_expected(list_word_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void predict_list_step(logic md, key_t key);
        list_word_t w;
        int         i;
        int         new_held;
        logic       evict;
        w = '0;
        if (md == MODE_READOUT) begin
            if (held == 0) begin
                w.last = 1'b1;
                add_expected(w);
            end else begin
                for (i = 0; i < held; i++) begin
                    w.entry_valid = 1'b1;
                    w.out_key     = recent_ids[i];
                    w.fill_count  = FILL_W'(held);
                    w.last        = (i == held - 1);
                    add_expected(w);
                end
            end
            return;
        end
        for (i = 0; i < held; i++) begin
            if (recent_ids[i] == key) begin
                w.hit        = 1'b1;
                w.fill_count = FILL_W'(held);
                w.last       = 1'b1;
                add_expected(w);
                return;
            end
        end
        evict = (held >= kept_limit());
        if (evict) begin
            w.out_key = recent_ids[held-1];
            new_held  = held;
        end else begin
            new_held = held + 1;
        end
        for (i = new_held - 1; i > 0; i--) begin
            recent_ids[i] = recent_ids[i-1];
        end
        recent_ids[0] = key;
        held          = new_held;
        w.evicted     = evict;
        w.fill_count  = FILL_W'(held);
        w.last        = 1'b1;
        add_expected(w);
    endfunction

    function automatic void check_field(string name, logic [KEY_BITS-1:0] exp_v,
                                        logic [KEY_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held       = 0;
            capacity   = CAP_RESET;
            fail_count = 0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no expected word, out_key 0x%0h", m_out_key);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("hit", KEY_BITS'(want.hit), KEY_BITS'(m_hit));
                    check_field("evicted", KEY_BITS'(want.evicted), KEY_BITS'(m_evicted));
                    check_field("entry_valid", KEY_BITS'(want.entry_valid),
                                KEY_BITS'(m_entry_valid));
                    check_field("out_key", want.out_key, m_out_key);
                    check_field("fill_count", KEY_BITS'(want.fill_count),
                                KEY_BITS'(m_fill_count));
                    check_field("last", KEY_BITS'(want.last), KEY_BITS'(m_last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                capacity = cfg_data;
            end
            if (s_valid && s_ready) begin
                predict_list_step(s_mode, s_item_key);
            end
        end
        pending = expected_words.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Top of the recent-id list testbench: clock, reset, stimulus and verdict.
// Depends on dfrl_pkg, dedup_fifo_recent_list and dfrl_list_checker.
module tb;
    import dfrl_pkg::*;

    localparam int POOL_N      = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_mode;
    key_t              s_item_key;
    logic              m_valid;
    logic              m_ready;
    logic              m_hit;
    logic              m_evicted;
    logic              m_entry_valid;
    key_t              m_out_key;
    logic [FILL_W-1:0] m_fill_count;
    logic              m_last;
    int                fail_count;
    int                pending;
    int                idle_cycles = 0;
    logic              hold_off_req;
    logic              hold_off_done;
    key_t              key_pool [POOL_N];

    dedup_fifo_recent_list DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_item_key    (s_item_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_evicted     (m_evicted),
        .m_entry_valid (m_entry_valid),
        .m_out_key     (m_out_key),
        .m_fill_count  (m_fill_count),
        .m_last        (m_last)
    );

    dfrl_list_checker list_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_item_key    (s_item_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_evicted     (m_evicted),
        .m_entry_valid (m_entry_valid),
        .m_out_key     (m_out_key),
        .m_fill_count  (m_fill_count),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : result_ready_gen
        int gap;
        m_ready       = 1'b0;
        hold_off_done = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done <= 1'b1;
                m_ready       <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    end

    task automatic send_item(input logic md, input key_t key, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= md;
        s_item_key <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_items(input int count, input int pool_n, input bit no_gaps);
        int   k;
        int   r;
        logic md;
        key_t key;
        for (k = 0; k < count; k++) begin
            r  = $urandom_range(0, 99);
            md = (r < 12) ? MODE_READOUT : MODE_PRESENT;
            r  = $urandom_range(0, 99);
            if (r < 60) begin
                key = key_pool[$urandom_range(0, pool_n - 1)];
            end else begin
                key = $urandom;
            end
            send_item(md, key, no_gaps ? 0 : pick_gap());
        end
    endtask

    task automatic random_phase(input logic [CAP_W-1:0] cap, input int count,
                                input int pool_n);
        write_capacity(cap);
        random_items(count, pool_n, 1'b0);
        drain_results();
    endtask

    initial begin : stimulus
        int i;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_mode       = MODE_PRESENT;
        s_item_key   = '0;
        hold_off_req = 1'b0;
        for (i = 0; i < POOL_N; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Readout of the empty list, then capacity zero, which acts as one.
        send_item(MODE_READOUT, $urandom, 0);
        drain_results();
        write_capacity(CAP_W'(0));
        send_item(MODE_PRESENT, '0, 0);
        send_item(MODE_PRESENT, '1, 1);
        send_item(MODE_PRESENT, '1, 0);
        send_item(MODE_READOUT, '0, 0);
        drain_results();
        write_capacity(CAP_W'(1));
        send_item(MODE_PRESENT, '0, 0);
        send_item(MODE_READOUT, $urandom, 0);
        drain_results();
        write_capacity(CAP_W'(3));
        send_item(MODE_PRESENT, 32'hA5A5_A5A5, 0);
        send_item(MODE_PRESENT, 32'h5A5A_5A5A, 0);
        send_item(MODE_PRESENT, 32'h0000_0001, 2);
        send_item(MODE_READOUT, '1, 0);
        drain_results();

        // Capacity lowered below the fill: the fill must hold and hits still match.
        write_capacity(CAP_W'(2));
        send_item(MODE_PRESENT, 32'h0000_0002, 0);
        send_item(MODE_PRESENT, 32'h5A5A_5A5A, 0);
        send_item(MODE_READOUT, '0, 0);
        drain_results();

        random_phase(CAP_W'(6), 60, 10);
        random_phase(CAP_W'(12), 60, 16);

        write_capacity(CAP_W'(31));
        random_items(60, 24, 1'b0);
        s_valid      <= 1'b0;
        hold_off_req <= 1'b1;
        while (!hold_off_done) @(negedge aclk);
        random_items(40, 24, 1'b1);
        drain_results();

        random_phase(CAP_W'(17), 60, 24);
        random_phase(CAP_W'(16), 60, 20);
        random_phase(CAP_W'(4), 80, 12);

        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
